/* design/cpaf_pkg.sv */
// shared types and constants for the command packet admission filter
package cpaf_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned JOINT_W = 16;

  // apb register map: one 32-bit register per word
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_EXPECTED_JOINTS = 1'b0;

  localparam logic [JOINT_W-1:0] EXPECTED_JOINTS_RST = 16'd7;
  localparam logic [SEQ_W-1:0]   SERIAL_HALF         = 32'h8000_0000;

  typedef enum logic [2:0] {
    REASON_NONE   = 3'd0,
    REASON_DECODE = 3'd1,
    REASON_JOINTS = 3'd2,
    REASON_OWNER  = 3'd3,
    REASON_PORT   = 3'd4,
    REASON_STALE  = 3'd5
  } reason_t;

  typedef struct packed {
    logic                 decode_ok;
    logic [JOINT_W-1:0]   joint_count;
    logic [ADDR_W-1:0]    source_addr;
    logic [PORT_W-1:0]    source_port;
    logic [SEQ_W-1:0]     sequence_req;
    logic                 armed;
    logic [ADDR_W-1:0]    owner_addr;
    logic [EPOCH_W-1:0]   arm_epoch;
  } cmd_t;

  typedef struct packed {
    logic    accepted;
    reason_t drop_reason;
    logic    port_pinned_now;
  } res_t;

  typedef struct packed {
    logic [PORT_W-1:0]  pinned_port;
    logic [EPOCH_W-1:0] pin_epoch;
    logic [EPOCH_W-1:0] track_epoch;
    logic [ADDR_W-1:0]  track_addr;
    logic [PORT_W-1:0]  track_port;
    logic [SEQ_W-1:0]   last_sequence;
    logic               sequence_valid;
  } flt_state_t;

endpackage

/* design/cpaf_intf.sv */
// valid/ready channel interfaces for command packets and filter results
interface cpaf_cmd_if;
  logic                               valid;
  logic                               ready;
  logic                               decode_ok;
  logic [cpaf_pkg::JOINT_W-1:0]       joint_count;
  logic [cpaf_pkg::ADDR_W-1:0]        source_addr;
  logic [cpaf_pkg::PORT_W-1:0]        source_port;
  logic [cpaf_pkg::SEQ_W-1:0]         sequence_req;
  logic                               armed;
  logic [cpaf_pkg::ADDR_W-1:0]        owner_addr;
  logic [cpaf_pkg::EPOCH_W-1:0]       arm_epoch;

  modport source (
    output valid, decode_ok, joint_count, source_addr, source_port,
           sequence_req, armed, owner_addr, arm_epoch,
    input  ready
  );
  modport sink (
    input  valid, decode_ok, joint_count, source_addr, source_port,
           sequence_req, armed, owner_addr, arm_epoch,
    output ready
  );
endinterface

interface cpaf_res_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] drop_reason;
  logic       port_pinned_now;

  modport source (
    output valid, accepted, drop_reason, port_pinned_now,
    input  ready
  );
  modport sink (
    input  valid, accepted, drop_reason, port_pinned_now,
    output ready
  );
endinterface

/* design/cpaf_check.sv */
// admission decision for one packet and the next filter state
module cpaf_check (
  input  cpaf_pkg::cmd_t                      cmd,
  input  cpaf_pkg::flt_state_t                st,
  input  logic [cpaf_pkg::JOINT_W-1:0]        expected_joints,
  output cpaf_pkg::res_t                      res,
  output cpaf_pkg::flt_state_t                st_nxt
);

  logic                          owner_bad;
  logic [cpaf_pkg::PORT_W-1:0]   cur_pin;
  logic                          take_pin;
  logic [cpaf_pkg::PORT_W-1:0]   eff_pin;
  logic                          flow_same;
  logic [cpaf_pkg::SEQ_W-1:0]    seq_diff;
  logic                          seq_stale;
  cpaf_pkg::reason_t             reason;

  always_comb begin
    owner_bad = cmd.armed && (cmd.owner_addr != '0) && (cmd.source_addr != cmd.owner_addr);
    // a pin from an older epoch counts as released
    cur_pin   = (st.pin_epoch == cmd.arm_epoch) ? st.pinned_port : '0;
    take_pin  = cmd.armed && !owner_bad && (cur_pin == '0);
    eff_pin   = take_pin ? cmd.source_port : cur_pin;
    flow_same = (cmd.arm_epoch == st.track_epoch) && (cmd.source_addr == st.track_addr)
             && (cmd.source_port == st.track_port);
    seq_diff  = cmd.sequence_req - st.last_sequence;
    seq_stale = (seq_diff == '0) || ((seq_diff & cpaf_pkg::SERIAL_HALF) != '0);
  end

  always_comb begin
    st_nxt = st;
    reason = cpaf_pkg::REASON_NONE;
    res.port_pinned_now = 1'b0;
    if (!cmd.decode_ok) begin
      reason = cpaf_pkg::REASON_DECODE;
    end else if (cmd.joint_count != expected_joints) begin
      reason = cpaf_pkg::REASON_JOINTS;
    end else if (owner_bad) begin
      reason = cpaf_pkg::REASON_OWNER;
    end else begin
      // pin stays even if the packet is later dropped as stale
      if (take_pin) begin
        st_nxt.pinned_port  = cmd.source_port;
        st_nxt.pin_epoch    = cmd.arm_epoch;
        res.port_pinned_now = 1'b1;
      end
      if (cmd.armed && (cmd.source_port != eff_pin)) begin
        reason = cpaf_pkg::REASON_PORT;
      end else if (flow_same && st.sequence_valid && seq_stale) begin
        reason = cpaf_pkg::REASON_STALE;
      end else begin
        st_nxt.track_epoch    = cmd.arm_epoch;
        st_nxt.track_addr     = cmd.source_addr;
        st_nxt.track_port     = cmd.source_port;
        st_nxt.last_sequence  = cmd.sequence_req;
        st_nxt.sequence_valid = 1'b1;
      end
    end
    res.drop_reason = reason;
    res.accepted    = (reason == cpaf_pkg::REASON_NONE);
  end

endmodule

/* design/command_packet_admission_filter.sv */
// top level of the command packet admission filter
//
// Takes one decoded command packet header per transfer on in_if and returns one
// result per packet on out_if, in order: accepted, drop_reason and port_pinned_now.
// Throughput is one packet per clock while results are taken. The packet is
// captured in an input register, checked by a single pass of compare logic
// against the filter state, and the result is written to an output register in the
// same edge that updates the pin and sequence-tracking state, so the next packet
// always sees the state left by the one before it. While a result waits, the input
// register still takes one more packet; after that the input stalls until the
// result is taken. The joint-count register sits at apb byte address 0 and is
// decoded from paddr[2] alone; writes are single setup/access transfers and pready
// is always high. Writes with paddr[2] set are ignored, and such addresses read
// back as zero.
module command_packet_admission_filter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  cpaf_cmd_if.sink                              in_if,
  cpaf_res_if.source                            out_if,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [cpaf_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [cpaf_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [cpaf_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  // configuration
  logic [cpaf_pkg::JOINT_W-1:0] exp_joints_r;
  logic                         cfg_wr;
  logic                         reg_sel;

  // input register stage
  logic                         s1_valid_r;
  cpaf_pkg::cmd_t               s1_cmd_r;
  logic                         advance;

  // result register stage
  logic                         out_valid_r;
  cpaf_pkg::res_t               out_res_r;

  // filter state
  cpaf_pkg::flt_state_t         st_r;
  cpaf_pkg::flt_state_t         st_nxt;
  cpaf_pkg::res_t               res_nxt;

  // apb register access
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && (reg_sel == cpaf_pkg::REG_EXPECTED_JOINTS);
  assign prdata  = (reg_sel == cpaf_pkg::REG_EXPECTED_JOINTS)
                 ? {{(cpaf_pkg::CFG_DATA_W-cpaf_pkg::JOINT_W){1'b0}}, exp_joints_r}
                 : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_joints_r <= cpaf_pkg::EXPECTED_JOINTS_RST;
    end else if (cfg_wr) begin
      exp_joints_r <= pwdata[cpaf_pkg::JOINT_W-1:0];
    end
  end

  // pipeline flow control: the checked packet moves into the result register
  // whenever that register is empty or its result is being taken
  assign advance      = !out_valid_r || out_if.ready;
  assign in_if.ready  = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_cmd_r.decode_ok    <= in_if.decode_ok;
      s1_cmd_r.joint_count  <= in_if.joint_count;
      s1_cmd_r.source_addr  <= in_if.source_addr;
      s1_cmd_r.source_port  <= in_if.source_port;
      s1_cmd_r.sequence_req <= in_if.sequence_req;
      s1_cmd_r.armed        <= in_if.armed;
      s1_cmd_r.owner_addr   <= in_if.owner_addr;
      s1_cmd_r.arm_epoch    <= in_if.arm_epoch;
    end
  end

  // single-pass decision on the registered packet
  cpaf_check u_check (
    .cmd             (s1_cmd_r),
    .st              (st_r),
    .expected_joints (exp_joints_r),
    .res             (res_nxt),
    .st_nxt          (st_nxt)
  );

  // state and result commit together when the packet leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.accepted        = out_res_r.accepted;
  assign out_if.drop_reason     = out_res_r.drop_reason;
  assign out_if.port_pinned_now = out_res_r.port_pinned_now;

endmodule

/* bench/command_packet_admission_filter_tb.sv */
// self-checking testbench for the command packet admission filter
module command_packet_admission_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD      = 4;
  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned RX_HOLD_CYCLES  = 64;
  localparam int unsigned PHASES          = 9;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned TAIL_CYCLES     = 8;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned RUN_LIMIT_NS    = 1_000_000;

  // joint-count register sits at word 0 of the apb map
  localparam logic [cpaf_pkg::CFG_ADDR_W-1:0] JOINTS_ADDR =
    {cpaf_pkg::REG_EXPECTED_JOINTS, 2'b00};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // apb side, idle from time zero
  logic                            psel    = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite  = 1'b0;
  logic [cpaf_pkg::CFG_ADDR_W-1:0] paddr   = '0;
  logic [cpaf_pkg::CFG_DATA_W-1:0] pwdata  = '0;
  logic [cpaf_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  cpaf_cmd_if cmd_bus ();
  cpaf_res_if res_bus ();

  command_packet_admission_filter i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (cmd_bus),
    .out_if  (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // packets waiting to be driven, and verdicts waiting for their result transfer
  cpaf_pkg::cmd_t pending_cmds [$];
  cpaf_pkg::res_t verdict_q [$];

  // mirror of the filter state and of the joint-count register
  cpaf_pkg::flt_state_t          filter_st  = '0;
  logic [cpaf_pkg::JOINT_W-1:0]  joints_cfg = cpaf_pkg::EXPECTED_JOINTS_RST;

  int unsigned issued_total = 0;
  int unsigned taken_total  = 0;
  int unsigned results_seen = 0;
  int unsigned err_count    = 0;

  // idling knobs, changed only between phases
  int unsigned tx_gap_max   = 4;
  int unsigned rx_stall_max = 4;
  int unsigned tx_gap_left  = 0;
  int unsigned rx_stall_left = 0;
  logic        rx_block_req = 1'b0;
  logic        cmd_taken    = 1'b0;

  // sender-side flows used by the random part: a small pool so that
  // sequences, pins and owner checks actually interact
  logic [cpaf_pkg::ADDR_W-1:0]  flow_addr [4];
  logic [cpaf_pkg::PORT_W-1:0]  flow_port [4];
  logic [cpaf_pkg::SEQ_W-1:0]   flow_seq  [4];
  logic [1:0]                   flow_pick = '0;
  logic [cpaf_pkg::EPOCH_W-1:0] gen_epoch = '0;

  // admission decision for one packet, updating the mirrored pin and
  // sequence-tracking state the same way the block does
  function automatic cpaf_pkg::res_t admit_packet(input cpaf_pkg::cmd_t pkt);
    cpaf_pkg::res_t               verdict;
    cpaf_pkg::reason_t            why;
    logic                         pin_taken;
    logic [cpaf_pkg::PORT_W-1:0]  live_pin;
    logic [cpaf_pkg::SEQ_W-1:0]   seq_gap;
    why       = cpaf_pkg::REASON_NONE;
    pin_taken = 1'b0;
    if (!pkt.decode_ok) begin
      why = cpaf_pkg::REASON_DECODE;
    end else if (pkt.joint_count != joints_cfg) begin
      why = cpaf_pkg::REASON_JOINTS;
    end else if (pkt.armed && pkt.owner_addr != '0 && pkt.source_addr != pkt.owner_addr) begin
      why = cpaf_pkg::REASON_OWNER;
    end else begin
      if (pkt.armed) begin
        // a pin from an older epoch counts as released
        live_pin = (filter_st.pin_epoch == pkt.arm_epoch) ? filter_st.pinned_port : '0;
        if (live_pin == '0) begin
          filter_st.pinned_port = pkt.source_port;
          filter_st.pin_epoch   = pkt.arm_epoch;
          live_pin              = pkt.source_port;
          pin_taken             = 1'b1;
        end
        if (pkt.source_port != live_pin) why = cpaf_pkg::REASON_PORT;
      end
      if (why == cpaf_pkg::REASON_NONE) begin
        // any change of flow drops the tracked sequence
        if (pkt.arm_epoch != filter_st.track_epoch || pkt.source_addr != filter_st.track_addr ||
            pkt.source_port != filter_st.track_port) begin
          filter_st.sequence_valid = 1'b0;
        end
        seq_gap = pkt.sequence_req - filter_st.last_sequence;
        if (filter_st.sequence_valid &&
            (seq_gap == '0 || seq_gap >= cpaf_pkg::SERIAL_HALF)) begin
          why = cpaf_pkg::REASON_STALE;
        end else begin
          filter_st.track_epoch    = pkt.arm_epoch;
          filter_st.track_addr     = pkt.source_addr;
          filter_st.track_port     = pkt.source_port;
          filter_st.last_sequence  = pkt.sequence_req;
          filter_st.sequence_valid = 1'b1;
        end
      end
    end
    verdict.accepted        = (why == cpaf_pkg::REASON_NONE);
    verdict.drop_reason     = why;
    verdict.port_pinned_now = pin_taken;
    return verdict;
  endfunction

  task automatic flag_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // queue one packet for the driver
  task automatic offer(input logic d, input logic [cpaf_pkg::JOINT_W-1:0] j,
                       input logic [cpaf_pkg::ADDR_W-1:0] a,
                       input logic [cpaf_pkg::PORT_W-1:0] p,
                       input logic [cpaf_pkg::SEQ_W-1:0] s, input logic arm,
                       input logic [cpaf_pkg::ADDR_W-1:0] own,
                       input logic [cpaf_pkg::EPOCH_W-1:0] ep);
    pending_cmds.push_back({d, j, a, p, s, arm, own, ep});
    issued_total++;
  endtask

  // one apb transfer on the joint-count register: setup, then access;
  // a read is checked against the mirror, a write updates it at the write edge
  task automatic cfg_access(input logic wr, input logic [cpaf_pkg::CFG_DATA_W-1:0] wdat);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= JOINTS_ADDR;
    pwdata  <= wdat;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      joints_cfg = wdat[cpaf_pkg::JOINT_W-1:0];
    end else if (prdata !== cpaf_pkg::CFG_DATA_W'(joints_cfg)) begin
      flag_mismatch($sformatf("expected_joints readback exp %0d got %0d", joints_cfg, prdata));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // the sender holds off until every queued packet has had its result checked
  task automatic wait_drained();
    while (!(taken_total == issued_total && verdict_q.size() == 0)) @(posedge clk);
    @(negedge clk);
  endtask

  // command driver: a new packet goes out at the falling edge once the
  // previous one was taken and its drawn gap has run out
  always @(negedge clk) begin
    if (!rst_n) begin
      cmd_bus.valid <= 1'b0;
    end else if (!cmd_bus.valid || cmd_taken) begin
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        cmd_bus.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        {cmd_bus.decode_ok, cmd_bus.joint_count, cmd_bus.source_addr, cmd_bus.source_port,
         cmd_bus.sequence_req, cmd_bus.armed, cmd_bus.owner_addr, cmd_bus.arm_epoch}
          <= pending_cmds.pop_front();
        cmd_bus.valid <= 1'b1;
        tx_gap_left = $urandom_range(0, tx_gap_max);
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // result receiver: per-result stall draw, plus the long hold-off
  always @(negedge clk) begin
    if (!rst_n || rx_block_req) begin
      res_bus.ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  // long receiver hold-off, so the block backs up and stalls its input
  always begin
    wait (rx_block_req == 1'b1);
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_block_req = 1'b0;
  end

  // monitor: predict on every command transfer, check on every result transfer
  always @(posedge clk) begin
    cpaf_pkg::cmd_t seen;
    cpaf_pkg::res_t want;
    cmd_taken <= rst_n && cmd_bus.valid && cmd_bus.ready;
    if (rst_n && cmd_bus.valid && cmd_bus.ready) begin
      seen = {cmd_bus.decode_ok, cmd_bus.joint_count, cmd_bus.source_addr, cmd_bus.source_port,
              cmd_bus.sequence_req, cmd_bus.armed, cmd_bus.owner_addr, cmd_bus.arm_epoch};
      verdict_q.push_back(admit_packet(seen));
      taken_total++;
    end
    if (rst_n && res_bus.valid && res_bus.ready) begin
      rx_stall_left = $urandom_range(0, rx_stall_max);
      results_seen++;
      if (verdict_q.size() == 0) begin
        flag_mismatch($sformatf("result %0d with no packet pending: acc=%0b why=%0d pin=%0b",
                                results_seen, res_bus.accepted, res_bus.drop_reason,
                                res_bus.port_pinned_now));
      end else begin
        want = verdict_q.pop_front();
        if (res_bus.accepted !== want.accepted || res_bus.drop_reason !== want.drop_reason ||
            res_bus.port_pinned_now !== want.port_pinned_now) begin
          flag_mismatch($sformatf(
            "result %0d exp acc=%0b why=%0d pin=%0b got acc=%0b why=%0d pin=%0b",
            results_seen, want.accepted, want.drop_reason, want.port_pinned_now,
            res_bus.accepted, res_bus.drop_reason, res_bus.port_pinned_now));
        end
      end
    end
  end

  // hard limit on the run
  initial begin
    #RUN_LIMIT_NS;
    $display("end of test: mismatches");
    $finish;
  end

  localparam logic [cpaf_pkg::ADDR_W-1:0] HOST_A = 32'hC0A8_0A05;
  localparam logic [cpaf_pkg::ADDR_W-1:0] HOST_B = 32'hC0A8_0A09;
  localparam logic [cpaf_pkg::PORT_W-1:0] PORT_P = 16'd5000;
  localparam logic [cpaf_pkg::PORT_W-1:0] PORT_Q = 16'd5001;
  localparam logic [cpaf_pkg::PORT_W-1:0] PORT_R = 16'd7;

  initial begin
    int unsigned                  ph;
    int unsigned                  n;
    int unsigned                  k;
    int unsigned                  kind;
    logic [cpaf_pkg::JOINT_W-1:0] jv;
    logic [cpaf_pkg::SEQ_W-1:0]   seq_step;
    logic [cpaf_pkg::ADDR_W-1:0]  owner;

    // every block input known from time zero
    cmd_bus.valid        = 1'b0;
    cmd_bus.decode_ok    = 1'b0;
    cmd_bus.joint_count  = '0;
    cmd_bus.source_addr  = '0;
    cmd_bus.source_port  = '0;
    cmd_bus.sequence_req = '0;
    cmd_bus.armed        = 1'b0;
    cmd_bus.owner_addr   = '0;
    cmd_bus.arm_epoch    = '0;
    res_bus.ready        = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // register must come out of reset at its default
    cfg_access(1'b0, '0);

    // directed part, joint count at its reset value
    jv = cpaf_pkg::EXPECTED_JOINTS_RST;
    offer(1'b0, jv,       HOST_A, PORT_P, 32'd5, 1'b0, '0, '0);          // decode failure
    offer(1'b1, 16'hFFFF, HOST_A, PORT_P, 32'd5, 1'b0, '0, '0);          // joint count too high
    offer(1'b1, 16'h0000, HOST_A, PORT_P, 32'd5, 1'b0, '0, '0);          // joint count zero
    offer(1'b1, jv, HOST_A, PORT_P, 32'd5, 1'b0, '0, '0);                // first of a flow
    offer(1'b1, jv, HOST_A, PORT_P, 32'd5, 1'b0, '0, '0);                // equal sequence
    offer(1'b1, jv, HOST_A, PORT_P, 32'h8000_0005, 1'b0, '0, '0);        // exactly half behind
    offer(1'b0, jv, HOST_A, PORT_P, 32'd7, 1'b0, '0, '0);                // early drop keeps tracking
    offer(1'b1, jv, HOST_A, PORT_P, 32'h8000_0004, 1'b0, '0, '0);        // just under half ahead
    offer(1'b1, jv, HOST_A, PORT_P, 32'h8000_0005, 1'b0, HOST_B, '0);    // owner ignored unarmed
    offer(1'b1, jv, HOST_A, PORT_P, 32'h8000_0006, 1'b1, HOST_B, 32'd1); // owner mismatch
    offer(1'b1, jv, HOST_A, PORT_P, 32'd10, 1'b1, '0, 32'd1);            // pins the port
    offer(1'b1, jv, HOST_A, PORT_Q, 32'd11, 1'b1, HOST_A, 32'd1);        // other port dropped
    offer(1'b1, jv, HOST_A, PORT_P, 32'd10, 1'b1, HOST_A, 32'd1);        // stale, no new pin
    offer(1'b1, jv, HOST_A, PORT_P, 32'd100, 1'b0, '0, 32'd3);           // unarmed, new epoch
    offer(1'b1, jv, HOST_A, PORT_P, 32'd100, 1'b1, '0, 32'd3);           // old pin: pins, then stale
    offer(1'b1, jv, HOST_A, PORT_Q, 32'd101, 1'b1, '0, 32'd3);           // pin from this epoch holds
    offer(1'b1, jv, HOST_B, '0, 32'd1, 1'b1, '0, 32'd4);                 // pin by port zero
    offer(1'b1, jv, HOST_B, PORT_Q, 32'd2, 1'b1, '0, 32'd4);             // port zero reads unpinned
    offer(1'b1, jv, HOST_B, PORT_R, 32'd3, 1'b0, '0, 32'd4);             // unarmed leaves the pin
    offer(1'b1, jv, HOST_B, PORT_R, 32'd4, 1'b1, '0, 32'd4);             // still pinned to Q
    offer(1'b1, jv, HOST_A, PORT_Q, 32'hFFFF_FFFF, 1'b1, HOST_A, 32'd4); // owner matches source
    offer(1'b1, jv, HOST_A, PORT_Q, 32'h0000_0000, 1'b1, HOST_A, 32'd4); // sequence wraps
    offer(1'b1, jv, HOST_A, PORT_Q, 32'hFFFF_FFFF, 1'b1, HOST_A, 32'd4); // one behind
    offer(1'b1, jv, '1, '1, '1, 1'b1, '1, '1);                           // all-ones fields
    offer(1'b1, jv, '0, '0, '0, 1'b1, '0, '0);                           // all-zero fields
    wait_drained();

    // random phases, each under its own joint count and idling mix
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:          jv = '0;
        1:          jv = '1;
        PHASES - 1: jv = cpaf_pkg::EXPECTED_JOINTS_RST;
        default:    jv = cpaf_pkg::JOINT_W'($urandom_range(0, 65535));
      endcase
      cfg_access(1'b1, cpaf_pkg::CFG_DATA_W'(jv));
      cfg_access(1'b0, '0);

      case (ph % 4)
        0: begin tx_gap_max = 4; rx_stall_max = 4; end
        1: begin tx_gap_max = 0; rx_stall_max = 0; end
        2: begin tx_gap_max = 0; rx_stall_max = 4; end
        default: begin tx_gap_max = 4; rx_stall_max = 0; end
      endcase

      // fresh flows: two share a host, and every other phase one uses port zero
      for (k = 0; k < 4; k++) begin
        flow_addr[2'(k)] = $urandom;
        flow_port[2'(k)] = cpaf_pkg::PORT_W'($urandom);
        flow_seq[2'(k)]  = $urandom;
      end
      flow_addr[1] = flow_addr[0];
      if (ph % 2 == 1) flow_port[3] = '0;
      gen_epoch = gen_epoch + 1;

      // back-to-back traffic against a blocked receiver fills the block
      if (ph == 1) rx_block_req = 1'b1;

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 4) == 0) flow_pick = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 29) == 0) begin
          gen_epoch = $urandom_range(0, 1) ? gen_epoch + 1 : cpaf_pkg::EPOCH_W'($urandom);
        end
        if (kind < 10) begin
          // noise: any field value at all
          offer(1'($urandom),
                $urandom_range(0, 1) ? joints_cfg : cpaf_pkg::JOINT_W'($urandom),
                $urandom, cpaf_pkg::PORT_W'($urandom), $urandom, 1'($urandom),
                $urandom, $urandom);
        end else begin
          case ($urandom_range(0, 19))
            0:       seq_step = '0;
            1:       seq_step = cpaf_pkg::SERIAL_HALF;
            2:       seq_step = cpaf_pkg::SERIAL_HALF - 1;
            3:       seq_step = '1;
            4:       seq_step = $urandom;
            5, 6:    seq_step = 32'd0 - $urandom_range(1, 100);
            default: seq_step = $urandom_range(1, 8);
          endcase
          flow_seq[flow_pick] = flow_seq[flow_pick] + seq_step;
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: owner = '0;
            10, 11, 12, 13, 14, 15, 16:   owner = flow_addr[flow_pick];
            default:                      owner = flow_addr[2'($urandom_range(0, 3))];
          endcase
          // mostly well-formed; some decode failures and bad joint counts
          offer(kind >= 16,
                (kind >= 16 && kind < 22)
                  ? joints_cfg ^ cpaf_pkg::JOINT_W'($urandom_range(1, 65535))
                  : joints_cfg,
                flow_addr[flow_pick], flow_port[flow_pick], flow_seq[flow_pick],
                $urandom_range(0, 9) < 6, owner, gen_epoch);
        end
      end
      wait_drained();
    end

    // anything arriving now is a stray result
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && verdict_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
